### rtl/core/tws_pkg.sv
// Package for the three-wire serial master: word widths, register indexes,
// the result word type and the bit count clamp.
// No dependencies; every other file in rtl/core imports it.
package tws_pkg;

    localparam int WORD_BITS  = 16;
    localparam int BITS_W     = $clog2(WORD_BITS + 1);
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SEND_BITS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RECV_BITS = CFG_IDX_W'(1);

    localparam logic [CFG_DATA_W-1:0] SEND_BITS_RST = CFG_DATA_W'(5);
    localparam logic [CFG_DATA_W-1:0] RECV_BITS_RST = CFG_DATA_W'(15);

    typedef struct packed {
        logic                 clock_level;
        logic                 data_level;
        logic                 data_drive;
        logic                 select_active;
        logic                 busy_res;
        logic                 done_res;
        logic [WORD_BITS-1:0] received_word;
    } t_res;

    // A count of zero runs one bit; a count above the word runs the whole word.
    function automatic logic [BITS_W-1:0] clamp_count(input logic [CFG_DATA_W-1:0] c);
        logic [BITS_W-1:0] r;
        if (c == '0) begin
            r = BITS_W'(1);
        end else if (32'(c) > 32'(WORD_BITS)) begin
            r = BITS_W'(WORD_BITS);
        end else begin
            r = BITS_W'(c);
        end
        return r;
    endfunction

endpackage

### rtl/core/tws_req_if.sv
// Request channel of the three-wire serial master: one tick or start word.
// Depends on tws_pkg for the command word width.
interface tws_req_if;
    import tws_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [WORD_BITS-1:0] command_word;
    logic                 pin_sample;

    modport source (output valid, output req_type, output command_word,
                    output pin_sample, input ready);
    modport sink   (input valid, input req_type, input command_word,
                    input pin_sample, output ready);
endinterface

### rtl/core/tws_res_if.sv
// Result channel of the three-wire serial master: pin levels and status.
// Depends on tws_pkg for the received word width.
interface tws_res_if;
    import tws_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 clock_level;
    logic                 data_level;
    logic                 data_drive;
    logic                 select_active;
    logic                 busy_res;
    logic                 done_res;
    logic [WORD_BITS-1:0] received_word;

    modport source (output valid, output clock_level, output data_level,
                    output data_drive, output select_active, output busy_res,
                    output done_res, output received_word, input ready);
    modport sink   (input valid, input clock_level, input data_level,
                    input data_drive, input select_active, input busy_res,
                    input done_res, input received_word, output ready);
endinterface

### rtl/core/tws_res_buf.sv
// Two-word result buffer: output register plus skid register.
// Depends on tws_pkg for the result word type.
module tws_res_buf (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr_valid,
    output logic         o_wr_ready,
    input  tws_pkg::t_res i_wr_word,
    output logic         o_rd_valid,
    input  logic         i_rd_ready,
    output tws_pkg::t_res o_rd_word
);
    import tws_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_res r_out;
    t_res r_skid;
    logic push;
    logic pop;

    assign o_wr_ready = !r_skid_valid;
    assign push       = i_wr_valid && !r_skid_valid;
    assign pop        = r_out_valid && i_rd_ready;
    assign o_rd_valid = r_out_valid;
    assign o_rd_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (push) begin
                r_out <= i_wr_word;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid) begin
                r_out       <= i_wr_word;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= i_wr_word;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

### rtl/core/three_wire_serial_master_unit.sv
// Top level of the three-wire half-duplex serial master.
// Depends on tws_pkg, tws_req_if, tws_res_if and tws_res_buf.
//
// Each request word is one clock-phase tick of the serial link (req_type 0)
// or a start (req_type 1), and each gives exactly one result word with the
// pin levels after that tick. The block takes one request word per cycle;
// the phase sequencer updates in the cycle of acceptance and its result
// lands in a two-word output buffer, so a request word is taken while a
// result still waits, and ready drops only when both buffer words are full.
// A start loads the command word, asserts select and clears the receive
// word; command bits go out LSB first (clock low with the bit driven, then
// clock high), then the data line is released and response bits are sampled
// on the falling phase, filling the word MSB first. The tick that raises the
// clock after the last response bit drops select and flags done. Starts while
// busy are ignored. Bit counts are to be written through the config port only
// while the link is idle; the block itself does not enforce this. A count of
// zero runs one bit and a count above the word runs the word.
module three_wire_serial_master_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tws_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tws_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tws_req_if.sink                         i_req,
    tws_res_if.source                       o_res
);
    import tws_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEND = 2'd1,
        PH_RECV = 2'd2
    } t_phase;

    // Config registers
    logic [CFG_DATA_W-1:0] r_send_bits;
    logic [CFG_DATA_W-1:0] r_recv_bits;

    // Link state
    t_phase               r_phase, n_phase;
    logic                 r_clk_high, n_clk_high;
    logic [BITS_W-1:0]    r_bits_left, n_bits_left;
    logic [WORD_BITS-1:0] r_tx, n_tx;
    logic [WORD_BITS-1:0] r_rx, n_rx;
    logic                 r_drive_lvl, n_drive_lvl;
    logic                 n_done;

    logic buf_ready;
    logic push;
    t_res res_word;
    t_res rd_word;

    assign i_req.ready = buf_ready;
    assign push        = i_req.valid && buf_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_bits <= SEND_BITS_RST;
            r_recv_bits <= RECV_BITS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SEND_BITS: r_send_bits <= i_cfg_data;
                REG_RECV_BITS: r_recv_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // One clock phase of the link per tick
    always_comb begin
        n_phase     = r_phase;
        n_clk_high  = r_clk_high;
        n_bits_left = r_bits_left;
        n_tx        = r_tx;
        n_rx        = r_rx;
        n_drive_lvl = r_drive_lvl;
        n_done      = 1'b0;

        if (i_req.req_type) begin
            // Start only from idle; a start while busy changes nothing
            if (!(r_phase inside {PH_SEND, PH_RECV})) begin
                n_tx        = i_req.command_word;
                n_rx        = '0;
                n_bits_left = clamp_count(r_send_bits);
                n_drive_lvl = 1'b0;
                n_clk_high  = 1'b1;
                n_phase     = PH_SEND;
            end
        end else begin
            case (r_phase)
                PH_SEND: begin
                    if (r_clk_high) begin
                        // Falling phase: put the next command bit on the line
                        n_clk_high  = 1'b0;
                        n_drive_lvl = r_tx[0];
                    end else begin
                        n_clk_high  = 1'b1;
                        n_tx        = r_tx >> 1;
                        n_bits_left = r_bits_left - BITS_W'(1);
                        if (n_bits_left == '0) begin
                            // Turn the line around for the response
                            n_phase     = PH_RECV;
                            n_bits_left = clamp_count(r_recv_bits);
                            n_drive_lvl = 1'b0;
                        end
                    end
                end
                PH_RECV: begin
                    if (r_clk_high) begin
                        // Falling phase: sample, then make room unless last bit
                        n_clk_high  = 1'b0;
                        n_rx        = {r_rx[WORD_BITS-1:1], i_req.pin_sample};
                        n_bits_left = r_bits_left - BITS_W'(1);
                        if (n_bits_left != '0) begin
                            n_rx = {n_rx[WORD_BITS-2:0], 1'b0};
                        end
                    end else begin
                        n_clk_high = 1'b1;
                        if (r_bits_left == '0) begin
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end
                    end
                end
                default: begin
                    // Idle or unused code: ticks go to or stay in idle and hold everything else
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        res_word.clock_level   = n_clk_high;
        res_word.data_drive    = (n_phase == PH_SEND);
        res_word.data_level    = (n_phase == PH_SEND) ? n_drive_lvl : 1'b0;
        res_word.select_active = (n_phase != PH_IDLE);
        res_word.busy_res      = (n_phase != PH_IDLE);
        res_word.done_res      = n_done;
        res_word.received_word = n_rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_clk_high  <= 1'b1;
            r_bits_left <= '0;
            r_tx        <= '0;
            r_rx        <= '0;
            r_drive_lvl <= 1'b0;
        end else if (push) begin
            r_phase     <= n_phase;
            r_clk_high  <= n_clk_high;
            r_bits_left <= n_bits_left;
            r_tx        <= n_tx;
            r_rx        <= n_rx;
            r_drive_lvl <= n_drive_lvl;
        end
    end

    tws_res_buf u_res_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_req.valid),
        .o_wr_ready (buf_ready),
        .i_wr_word  (res_word),
        .o_rd_valid (o_res.valid),
        .i_rd_ready (o_res.ready),
        .o_rd_word  (rd_word)
    );

    assign o_res.clock_level   = rd_word.clock_level;
    assign o_res.data_level    = rd_word.data_level;
    assign o_res.data_drive    = rd_word.data_drive;
    assign o_res.select_active = rd_word.select_active;
    assign o_res.busy_res      = rd_word.busy_res;
    assign o_res.done_res      = rd_word.done_res;
    assign o_res.received_word = rd_word.received_word;

endmodule

### rtl/core/tws_checker.sv
// Port-level checks for the three-wire serial master, bound to the top level.
// Depends on tws_pkg for the received word width.
module tws_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [tws_pkg::WORD_BITS-1:0] i_res_word
);
    import tws_pkg::*;

    // Reset empties the result buffer
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // With no result pending the block must take a word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |-> i_req_ready)
        else $error("request stalled with empty result buffer");

    // An accepted word shows a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> i_res_valid)
        else $error("accepted word gave no result");

    // A stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_word)))
        else $error("stalled result changed");

endmodule

bind three_wire_serial_master_unit tws_checker u_tws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_word  (o_res.received_word)
);
